// ----- rtl/ssc_pkg.sv -----
// ----------------------------------------------------------------------------
// ssc_pkg
// Shared constants and payload types for the sphere-sphere contact pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package ssc_pkg;

   localparam int FRAC_BITS = 16;
   localparam int SUM_W     = 66;                       // sum of three squares
   localparam int ROOT_W    = 34;                       // floor(sqrt(sum))
   localparam int NRM_W     = FRAC_BITS + 2;            // signed normal magnitude
   localparam int QUO_W     = FRAC_BITS + 1;            // normal magnitude
   localparam int REM_W     = ROOT_W + FRAC_BITS + 1;   // divider remainder
   localparam int S_W       = 36;                       // rA + L - rB, signed
   localparam int PRD_W     = S_W + NRM_W;              // offset product

   // geometry carried alongside the length computation
   typedef struct packed {
      logic [2:0][31:0] a;      // first center, signed per axis
      logic [2:0][31:0] m;      // |B - A| per axis
      logic [2:0]       neg;    // B - A negative
      logic [30:0]      ra;
      logic [30:0]      rb;
   } ssc_geom_type;

   // context carried through the divider and the contact stages
   typedef struct packed {
      logic                    hit;
      logic signed [S_W-1:0]   s;
      logic [31:0]             pen;
      logic [2:0][31:0]        a;
      logic [2:0]              neg;
      logic [ROOT_W-1:0]       len;
   } ssc_ctx_type;

endpackage

`default_nettype wire

// ----- rtl/ssc_isqrt.sv -----
// ----------------------------------------------------------------------------
// ssc_isqrt
// Pipelined integer square root, one root bit per stage, with payload.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_isqrt (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       adv,
   input  wire logic                       in_valid,
   input  wire logic [ssc_pkg::SUM_W-1:0]  in_sum,
   input  wire ssc_pkg::ssc_geom_type      in_geom,
   output logic                            out_valid,
   output logic [ssc_pkg::ROOT_W-1:0]      out_root,
   output ssc_pkg::ssc_geom_type           out_geom
);
   import ssc_pkg::*;

   localparam int NS  = ROOT_W;
   localparam int RMW = 2 * ROOT_W;

   logic [RMW-1:0]    stg_rem  [0:NS];
   logic [ROOT_W-1:0] stg_root [0:NS];
   logic              stg_vld  [0:NS];
   ssc_geom_type      stg_geom [0:NS];

   assign stg_rem[0]  = RMW'(in_sum);
   assign stg_root[0] = '0;
   assign stg_vld[0]  = in_valid;
   assign stg_geom[0] = in_geom;

   for (genvar k = 0; k < NS; k++) begin : g_stage
      localparam int B = NS - 1 - k;
      logic [RMW-1:0]    trial;
      logic              take;
      logic [RMW-1:0]    rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RMW-1:0]    rem_ff;
      logic [ROOT_W-1:0] root_ff;
      logic              vld_ff;
      ssc_geom_type      geom_ff;

      // (r + 2^B)^2 - r^2 = r*2^(B+1) + 2^(2B)
      assign trial   = (RMW'(stg_root[k]) << (B + 1)) + (RMW'(1) << (2 * B));
      assign take    = stg_rem[k] >= trial;
      assign rem_in  = take ? stg_rem[k] - trial : stg_rem[k];
      assign root_in = take ? stg_root[k] | (ROOT_W'(1) << B) : stg_root[k];

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= stg_vld[k];
         end
         if (adv) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            geom_ff <= stg_geom[k];
         end
      end

      assign stg_rem[k+1]  = rem_ff;
      assign stg_root[k+1] = root_ff;
      assign stg_vld[k+1]  = vld_ff;
      assign stg_geom[k+1] = geom_ff;
   end

   assign out_valid = stg_vld[NS];
   assign out_root  = stg_root[NS];
   assign out_geom  = stg_geom[NS];

endmodule

`default_nettype wire

// ----- rtl/sphere_sphere_contact.sv -----
// Pipeline: 57 register stages (3 setup, 34 square-root, 1 hit test,
// 17 divider, 1 multiply, 1 output).
// Throughput: one request per cycle; the pipeline freezes as a whole while a
// result is held unaccepted, and req_ready is low only then.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
// ----------------------------------------------------------------------------
// sphere_sphere_contact
// Sphere pair contact test: distance, penetration, unit normal, contact point.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_sphere_contact (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [31:0] req_center_a_x,
   input  wire logic [31:0] req_center_a_y,
   input  wire logic [31:0] req_center_a_z,
   input  wire logic [30:0] req_radius_a,
   input  wire logic [31:0] req_center_b_x,
   input  wire logic [31:0] req_center_b_y,
   input  wire logic [31:0] req_center_b_z,
   input  wire logic [30:0] req_radius_b,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_hit_found,
   output logic [31:0]      rsp_contact_x,
   output logic [31:0]      rsp_contact_y,
   output logic [31:0]      rsp_contact_z,
   output logic [17:0]      rsp_normal_x,
   output logic [17:0]      rsp_normal_y,
   output logic [17:0]      rsp_normal_z,
   output logic [31:0]      rsp_penetration
);
   import ssc_pkg::*;

   localparam int DS   = QUO_W;        // one quotient bit per divider stage
   localparam int POSW = PRD_W + 2;

   // whole pipeline advances unless the output holds an unaccepted result
   logic adv;
   logic rsp_valid_ff;
   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   // ---------------- stage 1: center difference and magnitude -------------
   logic [2:0][31:0] in_a, in_b;
   ssc_geom_type     geom1_in, geom1_ff;
   logic             vld1_ff;

   assign in_a = {req_center_a_z, req_center_a_y, req_center_a_x};
   assign in_b = {req_center_b_z, req_center_b_y, req_center_b_x};

   always_comb begin
      logic signed [32:0] d;
      geom1_in    = '0;
      geom1_in.a  = in_a;
      geom1_in.ra = req_radius_a;
      geom1_in.rb = req_radius_b;
      for (int i = 0; i < 3; i++) begin
         d = $signed({in_b[i][31], in_b[i]}) - $signed({in_a[i][31], in_a[i]});
         geom1_in.neg[i] = d[32];
         geom1_in.m[i]   = d[32] ? 32'(-d) : d[31:0];
      end
   end

   // ---------------- stage 2: squares; stage 3: sum ------------------------
   logic [2:0][63:0] sq_ff;
   ssc_geom_type     geom2_ff, geom3_ff;
   logic             vld2_ff, vld3_ff;
   logic [SUM_W-1:0] sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
      end else if (adv) begin
         vld1_ff <= req_valid;
         vld2_ff <= vld1_ff;
         vld3_ff <= vld2_ff;
      end
      if (adv) begin
         geom1_ff <= geom1_in;
         for (int i = 0; i < 3; i++) begin
            sq_ff[i] <= 64'(geom1_ff.m[i]) * 64'(geom1_ff.m[i]);
         end
         geom2_ff <= geom1_ff;
         sum_ff   <= SUM_W'(sq_ff[0]) + SUM_W'(sq_ff[1]) + SUM_W'(sq_ff[2]);
         geom3_ff <= geom2_ff;
      end
   end

   // ---------------- length: pipelined square root -------------------------
   logic              sq_vld;
   logic [ROOT_W-1:0] root_len;
   ssc_geom_type      sq_geom;

   ssc_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld3_ff),
      .in_sum    (sum_ff),
      .in_geom   (geom3_ff),
      .out_valid (sq_vld),
      .out_root  (root_len),
      .out_geom  (sq_geom)
   );

   // ---------------- hit test, alpha numerator, divider setup --------------
   ssc_ctx_type           prep_in, prep_ff;
   logic [2:0][REM_W-1:0] prep_rem_in, prep_rem_ff;
   logic                  prep_vld_ff;

   always_comb begin
      logic [ROOT_W-1:0] rsum;
      rsum        = ROOT_W'(sq_geom.ra) + ROOT_W'(sq_geom.rb);
      prep_in     = '0;
      prep_in.hit = (root_len != '0) && (rsum >= root_len);
      prep_in.s   = $signed(S_W'(sq_geom.ra)) + $signed(S_W'(root_len))
                    - $signed(S_W'(sq_geom.rb));
      prep_in.pen = 32'(rsum - root_len);
      prep_in.a   = sq_geom.a;
      prep_in.neg = sq_geom.neg;
      prep_in.len = root_len;
      for (int i = 0; i < 3; i++) begin
         // round to nearest: (m * 2^F + L/2) / L
         prep_rem_in[i] = (REM_W'(sq_geom.m[i]) << FRAC_BITS) + REM_W'(root_len >> 1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prep_vld_ff <= 1'b0;
      end else if (adv) begin
         prep_vld_ff <= sq_vld;
      end
      if (adv) begin
         prep_ff     <= prep_in;
         prep_rem_ff <= prep_rem_in;
      end
   end

   // ---------------- normal: restoring division, three lanes ---------------
   // quotient never exceeds 2^F, so only F+1 quotient bits are developed
   logic                  stg_vld [0:DS];
   ssc_ctx_type           stg_ctx [0:DS];
   logic [2:0][REM_W-1:0] stg_rem [0:DS];
   logic [2:0][QUO_W-1:0] stg_q   [0:DS];

   assign stg_vld[0] = prep_vld_ff;
   assign stg_ctx[0] = prep_ff;
   assign stg_rem[0] = prep_rem_ff;
   assign stg_q[0]   = '0;

   for (genvar k = 0; k < DS; k++) begin : g_div
      localparam int B = DS - 1 - k;
      logic [REM_W-1:0]      dsh;
      logic [2:0][REM_W-1:0] rem_in;
      logic [2:0][QUO_W-1:0] q_in;
      logic                  vld_ff;
      ssc_ctx_type           ctx_ff;
      logic [2:0][REM_W-1:0] rem_ff;
      logic [2:0][QUO_W-1:0] q_ff;

      assign dsh = REM_W'(stg_ctx[k].len) << B;

      always_comb begin
         for (int i = 0; i < 3; i++) begin
            if (stg_rem[k][i] >= dsh) begin
               rem_in[i] = stg_rem[k][i] - dsh;
               q_in[i]   = stg_q[k][i] | (QUO_W'(1) << B);
            end else begin
               rem_in[i] = stg_rem[k][i];
               q_in[i]   = stg_q[k][i];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff <= 1'b0;
         end else if (adv) begin
            vld_ff <= stg_vld[k];
         end
         if (adv) begin
            ctx_ff <= stg_ctx[k];
            rem_ff <= rem_in;
            q_ff   <= q_in;
         end
      end

      assign stg_vld[k+1] = vld_ff;
      assign stg_ctx[k+1] = ctx_ff;
      assign stg_rem[k+1] = rem_ff;
      assign stg_q[k+1]   = q_ff;
   end

   // ---------------- signed normal and offset product ----------------------
   logic signed [NRM_W-1:0] nrm_in  [3];
   logic signed [NRM_W-1:0] nrm_ff  [3];
   logic signed [PRD_W-1:0] prod_ff [3];
   ssc_ctx_type             mul_ff;
   logic                    mul_vld_ff;

   always_comb begin
      logic signed [NRM_W-1:0] mag;
      for (int i = 0; i < 3; i++) begin
         mag       = $signed(NRM_W'(stg_q[DS][i]));
         nrm_in[i] = stg_ctx[DS].neg[i] ? -mag : mag;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (adv) begin
         mul_vld_ff <= stg_vld[DS];
      end
      if (adv) begin
         mul_ff <= stg_ctx[DS];
         for (int i = 0; i < 3; i++) begin
            nrm_ff[i]  <= nrm_in[i];
            prod_ff[i] <= PRD_W'(stg_ctx[DS].s) * PRD_W'(nrm_in[i]);
         end
      end
   end

   // ---------------- contact point: round, offset, saturate ----------------
   logic [2:0][31:0] pos_in;

   always_comb begin
      logic [PRD_W:0]         pm;
      logic [PRD_W:0]         om;
      logic signed [POSW-1:0] pos;
      for (int i = 0; i < 3; i++) begin
         pm  = prod_ff[i][PRD_W-1] ? (PRD_W+1)'(-prod_ff[i]) : (PRD_W+1)'(prod_ff[i]);
         if (prod_ff[i][PRD_W-1]) begin
            pm = (PRD_W+1)'(-$signed({prod_ff[i][PRD_W-1], prod_ff[i]}));
         end
         // half of alpha * n, rounded half away from zero
         om  = (pm + ((PRD_W+1)'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
         pos = $signed(POSW'($signed(mul_ff.a[i])));
         if (prod_ff[i][PRD_W-1]) begin
            pos = pos - $signed(POSW'(om));
         end else begin
            pos = pos + $signed(POSW'(om));
         end
         if (pos > $signed(POSW'(32'h7fff_ffff))) begin
            pos_in[i] = 32'h7fff_ffff;
         end else if (pos < -$signed(POSW'(33'h1_0000_0000 >> 1))) begin
            pos_in[i] = 32'h8000_0000;
         end else begin
            pos_in[i] = pos[31:0];
         end
      end
   end

   // ---------------- output register ---------------------------------------
   logic             hit_ff;
   logic [2:0][31:0] contact_ff;
   logic [2:0][17:0] normal_ff;
   logic [31:0]      pen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= mul_vld_ff;
      end
      if (adv) begin
         hit_ff <= mul_ff.hit;
         pen_ff <= mul_ff.hit ? mul_ff.pen : '0;
         for (int i = 0; i < 3; i++) begin
            contact_ff[i] <= mul_ff.hit ? pos_in[i] : '0;
            normal_ff[i]  <= mul_ff.hit ? 18'(nrm_ff[i]) : '0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hit_found   = hit_ff;
   assign rsp_contact_x   = contact_ff[0];
   assign rsp_contact_y   = contact_ff[1];
   assign rsp_contact_z   = contact_ff[2];
   assign rsp_normal_x    = normal_ff[0];
   assign rsp_normal_y    = normal_ff[1];
   assign rsp_normal_z    = normal_ff[2];
   assign rsp_penetration = pen_ff;

endmodule

`default_nettype wire

// ----- rtl/ssc_checker.sv -----
// ----------------------------------------------------------------------------
// ssc_checker
// Port-level checks for the sphere-sphere contact block, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ssc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        rsp_hit_found,
   input wire logic [31:0] rsp_contact_x,
   input wire logic [17:0] rsp_normal_x,
   input wire logic [17:0] rsp_normal_y,
   input wire logic [17:0] rsp_normal_z,
   input wire logic [31:0] rsp_penetration
);

   // a held result stalls the request side
   a_stall_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while result stalled");

   // a held result stays valid and keeps its contact x and penetration
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_contact_x)
                                  && $stable(rsp_penetration))
      else $error("stalled result changed");

   // a miss carries zero penetration and zero normals
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit_found |-> rsp_penetration == 32'd0
         && rsp_normal_x == 18'd0 && rsp_normal_y == 18'd0 && rsp_normal_z == 18'd0)
      else $error("miss with nonzero fields");

   // x component of the unit normal stays within one
   a_normal_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_found |-> $signed(rsp_normal_x) <= 18'sd65536
         && $signed(rsp_normal_x) >= -18'sd65536)
      else $error("normal out of range");

endmodule

bind sphere_sphere_contact ssc_checker u_ssc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_hit_found   (rsp_hit_found),
   .rsp_contact_x   (rsp_contact_x),
   .rsp_normal_x    (rsp_normal_x),
   .rsp_normal_y    (rsp_normal_y),
   .rsp_normal_z    (rsp_normal_z),
   .rsp_penetration (rsp_penetration)
);

`default_nettype wire

// ----- tb/tb_sphere_sphere_contact.sv -----
// ----------------------------------------------------------------------------
// tb_sphere_sphere_contact
// Drives random and corner sphere pairs through the contact pipeline under
// random stalls on both channels and checks every result against an
// in-bench contact predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_sphere_sphere_contact;
   timeunit 1ns;
   timeprecision 1ps;

   import ssc_pkg::*;

   localparam int LATENCY   = 57;
   localparam int MAX_CYCLE = 400000;

   typedef struct {
      logic [31:0] ax, ay, az;
      logic [30:0] ra;
      logic [31:0] bx, by, bz;
      logic [30:0] rb;
   } pair_type;

   typedef struct {
      logic        hit;
      logic [31:0] cx, cy, cz;
      logic [17:0] nx, ny, nz;
      logic [31:0] pen;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_center_a_x = '0, req_center_a_y = '0, req_center_a_z = '0;
   logic [30:0] req_radius_a = '0;
   logic [31:0] req_center_b_x = '0, req_center_b_y = '0, req_center_b_z = '0;
   logic [30:0] req_radius_b = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_hit_found;
   logic [31:0] rsp_contact_x, rsp_contact_y, rsp_contact_z;
   logic [17:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic [31:0] rsp_penetration;

   pair_type    pending_pairs[$];
   contact_type expected_contacts[$];
   int          errors = 0;
   int          cycle = 0;
   bit          stim_done = 1'b0;
   bit          req_acc = 1'b0;   // request taken at the last rising edge
   int          hold_off = 0;     // long receiver hold-off, in cycles

   sphere_sphere_contact u_top (.*);

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Predictor: exact integer math on wide vectors
   // ------------------------------------------------------------------------
   function automatic logic signed [33:0] round_div(logic signed [127:0] num,
                                                    logic [127:0] den);
      logic [127:0] mag;
      mag = num[127] ? -num : num;
      mag = (mag + (den >> 1)) / den;
      return num[127] ? -mag : mag;
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      contact_type         r;
      logic signed [63:0]  a[3], d[3], s, pos, n;
      logic signed [127:0] prod, om;
      logic [127:0]        sum, root, trial;
      logic [63:0]         m;
      r = '{default: '0};
      a[0] = $signed(p.ax); a[1] = $signed(p.ay); a[2] = $signed(p.az);
      d[0] = $signed(p.bx) - a[0];
      d[1] = $signed(p.by) - a[1];
      d[2] = $signed(p.bz) - a[2];
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         m = d[i][63] ? -d[i] : d[i];
         sum += 128'(m) * 128'(m);
      end
      root = '0;
      for (int b = 33; b >= 0; b--) begin
         trial = root | (128'd1 << b);
         if (trial * trial <= sum) root = trial;
      end
      if (root == 0 || 128'(p.ra) + 128'(p.rb) < root) return r;
      r.hit = 1'b1;
      s = 64'(p.ra) + 64'(root) - 64'(p.rb);
      for (int i = 0; i < 3; i++) begin
         n = round_div(128'(d[i]) <<< FRAC_BITS, root);
         prod = 128'(s) * 128'(n);
         om = prod[127] ? -prod : prod;
         om = (om + (128'd1 << FRAC_BITS)) >> (FRAC_BITS + 1);
         if (prod[127]) om = -om;
         pos = a[i] + 64'(om);
         if (pos > 64'sd2147483647) pos = 64'sd2147483647;
         if (pos < -64'sd2147483648) pos = -64'sd2147483648;
         unique case (i)
            0: begin r.cx = pos[31:0]; r.nx = n[17:0]; end
            1: begin r.cy = pos[31:0]; r.ny = n[17:0]; end
            default: begin r.cz = pos[31:0]; r.nz = n[17:0]; end
         endcase
      end
      r.pen = 32'(128'(p.ra) + 128'(p.rb) - root);
      return r;
   endfunction

   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 55) return 0;
      if (k < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // ------------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------------
   function automatic logic [31:0] rnd_coord();
      unique case ($urandom_range(0, 3))
         0:       return $urandom();
         1:       return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
         2:       return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 26)) - (1 << 25));
      endcase
   endfunction

   task automatic add_pair(logic [31:0] ax, ay, az, logic [30:0] ra,
                           logic [31:0] bx, by, bz, logic [30:0] rb);
      pair_type p;
      p = '{ax, ay, az, ra, bx, by, bz, rb};
      pending_pairs = {pending_pairs, p};
   endtask

   initial begin
      pair_type p;
      // directed: coincident, touching, separate, inside, extremes
      add_pair(0, 0, 0, 31'h10000, 0, 0, 0, 31'h10000);
      add_pair(0, 0, 0, 31'h10000, 32'h20000, 0, 0, 31'h10000);
      add_pair(0, 0, 0, 31'h10000, 32'h20001, 0, 0, 31'h10000);
      add_pair(0, 0, 0, 31'h8000, 0, 32'h10000, 0, 31'h40000);
      add_pair(0, 0, 0, 31'h40000, 0, 0, 32'hffff_0000, 31'h8000);
      add_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1,
               32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1);
      add_pair(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, '1,
               32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1);
      add_pair(32'h7fff_0000, 0, 0, '1, 32'h7fff_ffff, 0, 0, '0);
      add_pair(32'h8000_0000, 0, 0, '1, 32'h8000_0001, 0, 0, '1);
      add_pair(0, 0, 0, '0, 32'h1, 32'h1, 32'h1, 31'h2);
      add_pair(0, 0, 0, '0, 0, 0, 0, '0);
      add_pair(32'h1234, 32'h5678, 32'h9abc, 31'h30000,
               32'hffff_1234, 32'h1_5678, 32'h9abc, 31'h30000);
      add_pair('1, '1, '1, '1, '1, '1, 32'hffff_fffe, '0);
      for (int k = 0; k < 500; k++) begin
         p.ax = rnd_coord(); p.ay = rnd_coord(); p.az = rnd_coord();
         if ($urandom_range(0, 3) != 0) begin
            // nearby second sphere so most pairs are hits
            p.bx = p.ax + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            p.by = p.ay + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            p.bz = p.az + 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
            p.ra = 31'($urandom_range(0, 1 << 20));
            p.rb = 31'($urandom_range(0, 1 << 20));
         end else begin
            p.bx = rnd_coord(); p.by = rnd_coord(); p.bz = rnd_coord();
            p.ra = 31'($urandom()); p.rb = 31'($urandom());
         end
         pending_pairs = {pending_pairs, p};
      end
   end

   // ------------------------------------------------------------------------
   // Driver: changes on the falling edge
   // ------------------------------------------------------------------------
   // request handshake as seen at the rising edge
   always @(posedge clock) begin
      req_acc = !reset && req_valid && req_ready;
   end

   int  req_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (req_acc) begin
            expected_contacts = {expected_contacts,
                                 predict_contact(pending_pairs.pop_front())};
            req_gap = gap_len();
         end
         if (!req_valid || req_acc) begin
            if (req_gap > 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
               req_valid      <= 1'b1;
               req_center_a_x <= pending_pairs[0].ax;
               req_center_a_y <= pending_pairs[0].ay;
               req_center_a_z <= pending_pairs[0].az;
               req_radius_a   <= pending_pairs[0].ra;
               req_center_b_x <= pending_pairs[0].bx;
               req_center_b_y <= pending_pairs[0].by;
               req_center_b_z <= pending_pairs[0].bz;
               req_radius_b   <= pending_pairs[0].rb;
            end else begin
               req_valid <= 1'b0;
               stim_done = 1'b1;
            end
         end
      end
   end

   // receiver readiness: one long hold-off early on to fill the pipeline
   int rsp_gap = 0;
   always @(negedge clock) begin
      if (!reset) begin
         if (cycle == 200) hold_off = 300;
         if (hold_off > 0) begin
            hold_off--;
            rsp_ready <= 1'b0;
         end else if (rsp_gap > 0) begin
            rsp_gap--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_gap = gap_len();
            rsp_ready <= 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: sample at the rising edge
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      contact_type e;
      cycle <= cycle + 1;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_contacts.size() == 0) begin
            $error("unexpected result");
            errors++;
         end else begin
            e = expected_contacts.pop_front();
            if (rsp_hit_found !== e.hit) begin
               $error("hit_found exp %0d got %0d", e.hit, rsp_hit_found); errors++;
            end
            if (rsp_contact_x !== e.cx) begin
               $error("contact_x exp %h got %h", e.cx, rsp_contact_x); errors++;
            end
            if (rsp_contact_y !== e.cy) begin
               $error("contact_y exp %h got %h", e.cy, rsp_contact_y); errors++;
            end
            if (rsp_contact_z !== e.cz) begin
               $error("contact_z exp %h got %h", e.cz, rsp_contact_z); errors++;
            end
            if (rsp_normal_x !== e.nx) begin
               $error("normal_x exp %h got %h", e.nx, rsp_normal_x); errors++;
            end
            if (rsp_normal_y !== e.ny) begin
               $error("normal_y exp %h got %h", e.ny, rsp_normal_y); errors++;
            end
            if (rsp_normal_z !== e.nz) begin
               $error("normal_z exp %h got %h", e.nz, rsp_normal_z); errors++;
            end
            if (rsp_penetration !== e.pen) begin
               $error("penetration exp %h got %h", e.pen, rsp_penetration); errors++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Reset, end of run, timeout
   // ------------------------------------------------------------------------
   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock) reset = 1'b0;
      while (!(stim_done && expected_contacts.size() == 0) && cycle < MAX_CYCLE)
         @(posedge clock);
      if (cycle >= MAX_CYCLE) begin
         $display("FAILURE");
      end else begin
         repeat (2 * LATENCY) @(posedge clock);
         if (errors == 0 && expected_contacts.size() == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
      end
      $finish;
   end

endmodule

`default_nettype wire
